@@ rtl/ptt_pkg.sv @@
// Shared types and codes for the periodic timer table.
package ptt_pkg;

    // Request codes carried in the input tuser
    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_KILL = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam int ID_W   = 31;
    localparam int TIME_W = 32;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_KILLED    = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_FIRED     = 3'd4,
        ST_NONE      = 3'd5
    } t_status;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] last_fire;
    } t_entry;

    // One result word from the sequencer to the output register
    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] id;
        logic            last;
    } t_result;

endpackage

@@ rtl/ptt_entry_ram.sv @@
// Entry memory: one write port, one read port, registered read data.
module ptt_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ptt_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output ptt_pkg::t_entry o_rdata
);
    import ptt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ptt_seq.sv @@
// Request sequencer: add, kill with gap closing, and tick walk over the entry memory.
module ptt_seq #(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [ptt_pkg::TIME_W-1:0]    i_period,
    input  logic [ptt_pkg::ID_W-1:0]      i_kill_id,
    input  logic [ptt_pkg::TIME_W-1:0]    i_now,
    // result side
    output logic                          o_push,
    input  logic                          i_out_ready,
    output ptt_pkg::t_result              o_res,
    // entry memory
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output ptt_pkg::t_entry               o_wdata,
    output logic                          o_re,
    output logic [AW-1:0]                 o_raddr,
    input  ptt_pkg::t_entry               i_rdata
);
    import ptt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ADD  = 8'b0000_0010,
        S_KRD  = 8'b0000_0100,
        S_KEV  = 8'b0000_1000,
        S_SRD  = 8'b0001_0000,
        S_SWR  = 8'b0010_0000,
        S_TRD  = 8'b0100_0000,
        S_TEV  = 8'b1000_0000
    } t_state;

    // emit flag kept apart from the state so the final word can wait on the output
    typedef enum logic {
        E_OFF = 1'b0,
        E_ON  = 1'b1
    } t_emit;

    t_state              r_state, n_state;
    t_emit               r_emit, n_emit;
    logic [CW-1:0]       r_count, n_count;
    logic [ID_W-1:0]     r_next_id, n_next_id;
    logic [AW-1:0]       r_idx, n_idx;
    logic [TIME_W-1:0]   r_period;
    logic [ID_W-1:0]     r_kid;
    logic [TIME_W-1:0]   r_now;
    logic                r_pend_valid, n_pend_valid;
    logic [ID_W-1:0]     r_pend_id, n_pend_id;
    t_status             r_res_status, n_res_status;
    logic [ID_W-1:0]     r_res_id, n_res_id;

    logic [CW:0]         w_idx_p1, w_idx_p2, w_count_x;
    logic [ID_W-1:0]     w_nid;
    logic [TIME_W-1:0]   w_diff;
    logic                w_fire;

    assign w_idx_p1  = (CW+1)'(r_idx) + (CW+1)'(1);
    assign w_idx_p2  = (CW+1)'(r_idx) + (CW+1)'(2);
    assign w_count_x = {1'b0, r_count};
    assign w_nid     = (r_next_id == {ID_W{1'b1}}) ? ID_W'(1) : r_next_id + ID_W'(1);
    assign w_diff    = r_now - i_rdata.last_fire;
    assign w_fire    = w_diff > i_rdata.period;

    assign o_in_ready = (r_state == S_IDLE) && (r_emit == E_OFF);

    // latch the request word
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_period <= i_period;
            r_kid    <= i_kill_id;
            r_now    <= i_now;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_emit       = r_emit;
        n_count      = r_count;
        n_next_id    = r_next_id;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        o_push       = 1'b0;
        o_res        = '{status: r_res_status, id: r_res_id, last: 1'b1};
        o_we         = 1'b0;
        o_waddr      = r_idx;
        o_wdata      = i_rdata;
        o_re         = 1'b0;
        o_raddr      = r_idx;

        if (r_emit == E_ON) begin
            // final word of a request
            if (i_out_ready) begin
                o_push = 1'b1;
                n_emit = E_OFF;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        n_idx        = '0;
                        n_pend_valid = 1'b0;
                        n_res_id     = '0;
                        unique case (i_mode)
                            MODE_ADD: n_state = S_ADD;
                            MODE_KILL: begin
                                if (r_count == '0) begin
                                    n_res_status = ST_NOT_FOUND;
                                    n_emit       = E_ON;
                                end else begin
                                    n_state = S_KRD;
                                end
                            end
                            MODE_TICK: begin
                                if (r_count == '0) begin
                                    n_res_status = ST_NONE;
                                    n_emit       = E_ON;
                                end else begin
                                    n_state = S_TRD;
                                end
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
                S_ADD: begin
                    if (w_count_x >= (CW+1)'(DEPTH)) begin
                        n_res_status = ST_FULL;
                        n_res_id     = '0;
                    end else begin
                        o_we         = 1'b1;
                        o_waddr      = AW'(r_count);
                        o_wdata      = '{id: w_nid, period: r_period, last_fire: '0};
                        n_count      = r_count + CW'(1);
                        n_next_id    = w_nid;
                        n_res_status = ST_ADDED;
                        n_res_id     = w_nid;
                    end
                    n_state = S_IDLE;
                    n_emit  = E_ON;
                end
                S_KRD: begin
                    o_re    = 1'b1;
                    n_state = S_KEV;
                end
                S_KEV: begin
                    if (i_rdata.id == r_kid) begin
                        if (w_idx_p1 < w_count_x) begin
                            n_state = S_SRD;
                        end else begin
                            n_count      = r_count - CW'(1);
                            n_res_status = ST_KILLED;
                            n_state      = S_IDLE;
                            n_emit       = E_ON;
                        end
                    end else if (w_idx_p1 < w_count_x) begin
                        n_idx   = AW'(w_idx_p1);
                        n_state = S_KRD;
                    end else begin
                        n_res_status = ST_NOT_FOUND;
                        n_state      = S_IDLE;
                        n_emit       = E_ON;
                    end
                end
                S_SRD: begin
                    // fetch the entry above the gap
                    o_re    = 1'b1;
                    o_raddr = AW'(w_idx_p1);
                    n_state = S_SWR;
                end
                S_SWR: begin
                    o_we = 1'b1;
                    if (w_idx_p2 < w_count_x) begin
                        n_idx   = AW'(w_idx_p1);
                        n_state = S_SRD;
                    end else begin
                        n_count      = r_count - CW'(1);
                        n_res_status = ST_KILLED;
                        n_state      = S_IDLE;
                        n_emit       = E_ON;
                    end
                end
                S_TRD: begin
                    o_re    = 1'b1;
                    n_state = S_TEV;
                end
                S_TEV: begin
                    // a firing entry releases the one held before it
                    if (!(w_fire && r_pend_valid && !i_out_ready)) begin
                        if (w_fire) begin
                            o_push       = r_pend_valid;
                            o_res        = '{status: ST_FIRED, id: r_pend_id, last: 1'b0};
                            o_we         = 1'b1;
                            o_wdata      = '{id: i_rdata.id, period: i_rdata.period,
                                             last_fire: r_now};
                            n_pend_valid = 1'b1;
                            n_pend_id    = i_rdata.id;
                        end
                        if (w_idx_p1 < w_count_x) begin
                            n_idx   = AW'(w_idx_p1);
                            n_state = S_TRD;
                        end else begin
                            if (w_fire || r_pend_valid) begin
                                n_res_status = ST_FIRED;
                                n_res_id     = w_fire ? i_rdata.id : r_pend_id;
                            end else begin
                                n_res_status = ST_NONE;
                                n_res_id     = '0;
                            end
                            n_state = S_IDLE;
                            n_emit  = E_ON;
                        end
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_emit       <= E_OFF;
            r_count      <= '0;
            r_next_id    <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_emit       <= n_emit;
            r_count      <= n_count;
            r_next_id    <= n_next_id;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pend_id    <= n_pend_id;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
    end

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count_x <= (CW+1)'(DEPTH))
        else $error("entry count beyond table depth");

    a_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_out_ready)
        else $error("result pushed into a full output register");

    a_mid_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_res.last) |-> (o_res.status == ST_FIRED))
        else $error("non-final word is not a firing");

    a_wr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && (r_state == S_TEV || r_state == S_SWR)) |-> ((CW+1)'(o_waddr) < w_count_x))
        else $error("write outside the live table");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1) || r_count == $past(r_count) - CW'(1)))
        else $error("entry count jumped");

endmodule

@@ rtl/periodic_timer_table.sv @@
// Top level of the periodic timer table: stream ports, entry memory, output register.
//
// Usage: one request word enters on the slave stream. tuser carries the mode
// (add, kill, tick); tdata carries period_ms, kill_id and now_ms. Each request
// produces result words on the master stream: tuser is the status, tdata the
// timer id, tlast marks the final word of the request. Add and kill give one
// word, the unused mode gives none; tick gives one word per firing entry in
// table order, or a single "none fired" word.
// Each entry step is a read of the entry memory followed by a compare and write
// back; a kill moves the entries above the hit down one place to close the gap.
// Kill or tick on an empty table answers without reading the entry memory.
// One request is in work at a time; the next is taken the cycle after the
// final word of the previous one enters the output register.
// Reset empties the table and restarts ids at 1; no memory clearing pass.
// A stalled receiver holds the output register; the walk then waits on the
// next firing entry and resumes without loss once the word is taken.
module periodic_timer_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,  // period_ms[31:0], kill_id[62:32], now_ms[94:63]
    input  logic [1:0]   i_s_tuser,  // mode[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [31:0]  o_m_tdata,  // timer_id[30:0]
    output logic [2:0]   o_m_tuser,  // status[2:0]
    output logic         o_m_tlast
);
    import ptt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic            w_push, w_out_ready;
    t_result         w_res;
    logic            w_we, w_re;
    logic [AW-1:0]   w_waddr, w_raddr;
    t_entry          w_wdata, w_rdata;
    logic            r_out_valid;
    t_result         r_out;

    ptt_seq #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_mode      (i_s_tuser),
        .i_period    (i_s_tdata[31:0]),
        .i_kill_id   (i_s_tdata[62:32]),
        .i_now       (i_s_tdata[94:63]),
        .o_push      (w_push),
        .i_out_ready (w_out_ready),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    ptt_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // output register, free when empty or being taken
    assign w_out_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && w_out_ready) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.id};
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the periodic timer table: stream driver, result monitor, predictor.
`timescale 1ns / 1ps

module testbench;
    import ptt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 390;
    localparam int TAIL_ITEMS   = 60;    // last stretch runs without idling
    localparam int HOLD_AT      = 150;   // requests in before the long receiver hold
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 200;   // random request that waits for an empty result queue
    localparam int SETTLE       = 60;    // wait after the last result word before the verdict

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] period_ms;
        logic [30:0] kill_id;
        logic [31:0] now_ms;
        bit          drain_first;   // hold back until all results are in
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [95:0] i_s_tdata = '0;    // period_ms[31:0], kill_id[62:32], now_ms[94:63]
    logic [1:0]  i_s_tuser = '0;    // mode[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // timer_id[30:0]
    logic [2:0]  o_m_tuser;         // status[2:0]
    logic        o_m_tlast;

    periodic_timer_table #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Request backlog and expected result words
    t_request req_backlog[$];
    t_result  due_results[$];
    t_request next_req;
    int       fail_count = 0;
    int       words_in = 0;
    int       src_gap = 0;
    int       sink_gap = 0;
    int       sink_hold_left = 0;
    bit       hold_done = 1'b0;

    // Predicted table contents
    logic [30:0] tbl_id [TABLE_DEPTH];
    logic [31:0] tbl_period [TABLE_DEPTH];
    logic [31:0] tbl_fired_at [TABLE_DEPTH];
    int          tbl_count = 0;
    logic [30:0] id_counter = '0;

    // Stimulus-side view of live ids, used to aim kills
    logic [30:0] plan_ids[$];
    logic [30:0] plan_last_id = '0;
    logic [31:0] plan_now = '0;

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Reset, held low at start and then released
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Append one expected result word
    function automatic void expect_word(input t_status status, input logic [30:0] id,
                                        input logic last);
        due_results.insert(due_results.size(), t_result'{status: status, id: id, last: last});
    endfunction

    // Table behavior: work out the result words of one request
    function automatic void predict_table_words(input logic [1:0] mode,
                                                input logic [31:0] period,
                                                input logic [30:0] kid,
                                                input logic [31:0] now);
        int          hit;
        int          last_hit;
        logic [31:0] elapsed;
        hit = -1;
        last_hit = -1;
        case (mode)
            MODE_ADD: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    expect_word(ST_FULL, '0, 1'b1);
                end else begin
                    id_counter = (id_counter == '1) ? 31'd1 : id_counter + 31'd1;
                    tbl_id[tbl_count] = id_counter;
                    tbl_period[tbl_count] = period;
                    tbl_fired_at[tbl_count] = '0;
                    tbl_count++;
                    expect_word(ST_ADDED, id_counter, 1'b1);
                end
            end
            MODE_KILL: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (hit < 0 && tbl_id[i] == kid) hit = i;
                end
                if (hit < 0) begin
                    expect_word(ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    // close the gap
                    for (int j = hit; j + 1 < tbl_count; j++) begin
                        tbl_id[j] = tbl_id[j + 1];
                        tbl_period[j] = tbl_period[j + 1];
                        tbl_fired_at[j] = tbl_fired_at[j + 1];
                    end
                    tbl_count--;
                    expect_word(ST_KILLED, '0, 1'b1);
                end
            end
            MODE_TICK: begin
                // first pass finds the final firing entry for tlast
                for (int i = 0; i < tbl_count; i++) begin
                    elapsed = now - tbl_fired_at[i];
                    if (elapsed > tbl_period[i]) last_hit = i;
                end
                for (int i = 0; i < tbl_count; i++) begin
                    elapsed = now - tbl_fired_at[i];
                    if (elapsed > tbl_period[i]) begin
                        tbl_fired_at[i] = now;
                        expect_word(ST_FIRED, tbl_id[i], (i == last_hit));
                    end
                end
                if (last_hit < 0)
                    expect_word(ST_NONE, '0, 1'b1);
            end
            default: ;  // unused mode: no effect, no word
        endcase
    endfunction

    // Queue one request and keep the stimulus view of live ids current
    task automatic queue_request(input logic [1:0] mode, input logic [31:0] period,
                                 input logic [30:0] kid, input logic [31:0] now,
                                 input bit drain);
        t_request r;
        r.mode = mode;
        r.period_ms = period;
        r.kill_id = kid;
        r.now_ms = now;
        r.drain_first = drain;
        req_backlog.insert(req_backlog.size(), r);
        if (mode == MODE_ADD && plan_ids.size() < TABLE_DEPTH) begin
            plan_last_id = (plan_last_id == '1) ? 31'd1 : plan_last_id + 31'd1;
            plan_ids.insert(plan_ids.size(), plan_last_id);
        end else if (mode == MODE_KILL) begin
            for (int k = 0; k < plan_ids.size(); k++) begin
                if (plan_ids[k] == kid) begin
                    plan_ids.delete(k);
                    break;
                end
            end
        end
    endtask

    // Stimulus and end of run
    initial begin : stimulus
        int          n;
        int          pick;
        int          c;
        bit          grow;
        logic [31:0] period;
        logic [30:0] kid;

        // directed: empty table, extremes of period and time, full table, kills
        queue_request(MODE_TICK, $urandom, 31'($urandom), 32'd5, 1'b0);
        queue_request(MODE_KILL, $urandom, 31'd0, $urandom, 1'b0);
        queue_request(MODE_ADD, 32'd0, 31'($urandom), $urandom, 1'b0);
        queue_request(MODE_ADD, 32'hFFFF_FFFF, 31'($urandom), $urandom, 1'b0);
        queue_request(MODE_TICK, $urandom, 31'($urandom), 32'd0, 1'b0);
        queue_request(MODE_TICK, $urandom, 31'($urandom), 32'd1, 1'b0);
        queue_request(MODE_TICK, $urandom, 31'($urandom), 32'hFFFF_FFFF, 1'b0);
        queue_request(MODE_KILL, $urandom, 31'd2, $urandom, 1'b0);
        queue_request(MODE_KILL, $urandom, 31'd2, $urandom, 1'b0);
        queue_request(MODE_UNUSED, '1, '1, '1, 1'b0);
        for (int k = 0; k < TABLE_DEPTH - 1; k++)
            queue_request(MODE_ADD, 32'd10, 31'($urandom), $urandom, 1'b0);
        queue_request(MODE_ADD, 32'd3, 31'($urandom), $urandom, 1'b0);   // table full
        queue_request(MODE_TICK, $urandom, 31'($urandom), 32'd100, 1'b0); // every entry fires
        queue_request(MODE_KILL, $urandom, 31'd1, $urandom, 1'b0);   // head entry
        queue_request(MODE_KILL, $urandom, 31'd10, $urandom, 1'b0);  // middle entry
        queue_request(MODE_KILL, $urandom, 31'h7FFF_FFFF, $urandom, 1'b0);
        plan_now = 32'd100;

        // random: table grows and shrinks in turns, time mostly creeps forward
        n = 0;
        while (n < RANDOM_ITEMS) begin
            grow = ((n / 50) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                queue_request(MODE_UNUSED, $urandom, 31'($urandom), $urandom, 1'b0);
            end else if (pick < (grow ? 35 : 15)) begin
                c = $urandom_range(0, 9);
                period = (c == 0) ? 32'd0 : (c == 1) ? 32'hFFFF_FFFF :
                         (c == 2) ? $urandom : $urandom_range(1, 80);
                queue_request(MODE_ADD, period, 31'($urandom), $urandom, n == DRAIN_AT);
                n++;
            end else if (pick < 50) begin
                c = $urandom_range(0, 7);
                if (plan_ids.size() > 0 && c > 1)
                    kid = plan_ids[$urandom_range(0, plan_ids.size() - 1)];
                else if (c == 0)
                    kid = $urandom_range(0, 1) ? 31'd0 : plan_last_id;
                else
                    kid = 31'($urandom);
                queue_request(MODE_KILL, $urandom, kid, $urandom, n == DRAIN_AT);
                n++;
            end else begin
                c = $urandom_range(0, 99);
                if (c < 4)
                    plan_now = $urandom;
                else if (c < 7)
                    plan_now = 32'hFFFF_FFFF - $urandom_range(0, 30);
                else
                    plan_now = plan_now + $urandom_range(0, 45);
                queue_request(MODE_TICK, $urandom, 31'($urandom), plan_now, n == DRAIN_AT);
                n++;
            end
        end

        wait (req_backlog.size() == 0);
        @(posedge i_clk);
        while (i_s_tvalid || due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
            i_s_tuser <= '0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (req_backlog.size() == 0) begin
                i_s_tvalid <= 1'b0;
            end else if (req_backlog[0].drain_first &&
                         (i_s_tvalid || due_results.size() != 0)) begin
                // pause until every result is out
                i_s_tvalid <= 1'b0;
            end else if (src_gap > 0) begin
                src_gap--;
                i_s_tvalid <= 1'b0;
            end else begin
                next_req = req_backlog.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {1'b0, next_req.now_ms, next_req.kill_id, next_req.period_ms};
                i_s_tuser <= next_req.mode;
                // no gaps while the receiver is held off, none in the tail
                if (req_backlog.size() > TAIL_ITEMS && sink_hold_left == 0 &&
                    $urandom_range(0, 4) == 0)
                    src_gap = $urandom_range(1, 11);
            end
        end
    end

    // Result receiver ready, with one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (sink_hold_left > 0) begin
            sink_hold_left--;
            i_m_tready <= 1'b0;
        end else if (!hold_done && words_in >= HOLD_AT) begin
            hold_done = 1'b1;
            sink_hold_left = HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_m_tready <= 1'b0;
        end else if (req_backlog.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 10);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Monitor: check result words, then predict from accepted requests
    always @(posedge i_clk) begin : monitor
        t_result exp_word;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result word: status %0d, timer_id %0d",
                           o_m_tuser, o_m_tdata);
                    fail_count++;
                end else begin
                    exp_word = due_results.pop_front();
                    if (o_m_tuser !== exp_word.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_word.status, o_m_tuser);
                        fail_count++;
                    end
                    if (o_m_tdata !== {1'b0, exp_word.id}) begin
                        $error("timer_id mismatch: expected %0d, actual %0d",
                               exp_word.id, o_m_tdata);
                        fail_count++;
                    end
                    if (o_m_tlast !== exp_word.last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               exp_word.last, o_m_tlast);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                predict_table_words(i_s_tuser, i_s_tdata[31:0], i_s_tdata[62:32],
                                    i_s_tdata[94:63]);
                words_in++;
            end
        end
    end

endmodule
